// ===== hw/rtl/ple_pkg.sv =====
// ple_pkg: shared constants, types and codes of the positional list engine.
// Used by ple_cell, ple_chain, positional_list_engine_unit and ple_checker.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

    // list geometry
    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int DUMP_MAX    = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = $clog2(DEPTH);

    // field widths
    localparam int DATA_W     = 32;
    localparam int POS_W      = 5;
    localparam int FUNC_W     = 4;
    localparam int STAT_W     = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef logic [DATA_W-1:0] t_data;

    // per-cell update select
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } t_cell_mode;

    // whole-chain operation
    typedef enum logic [1:0] {
        CHAIN_HOLD,
        CHAIN_INS,
        CHAIN_DEL,
        CHAIN_ROT
    } t_chain_op;

    typedef struct packed {
        t_chain_op        op;
        logic [IDX_W-1:0] idx;
        t_data            value;
    } t_chain_ctl;

    // command codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_HEAD = 4'd0,
        FN_INS_TAIL = 4'd1,
        FN_INS_POS  = 4'd2,
        FN_DEL_HEAD = 4'd3,
        FN_DEL_TAIL = 4'd4,
        FN_DEL_POS  = 4'd5,
        FN_SUM      = 4'd6,
        FN_SEARCH   = 4'd7,
        FN_DUMP     = 4'd8
    } t_func;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// ple_cell: one storage cell of the list chain, holding a single entry.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_cell (
    input  logic               i_clk,
    input  ple_pkg::t_cell_mode i_mode,
    input  ple_pkg::t_data     i_load,
    input  ple_pkg::t_data     i_left,
    input  ple_pkg::t_data     i_right,
    output ple_pkg::t_data     o_data
);
    import ple_pkg::*;

    t_data r_data;
    t_data n_data;

    // next entry: keep, load new value, or take a neighbor's entry
    always_comb begin
        case (i_mode)
            CELL_HOLD:       n_data = r_data;
            CELL_LOAD:       n_data = i_load;
            CELL_FROM_LEFT:  n_data = i_left;
            CELL_FROM_RIGHT: n_data = i_right;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/ple_chain.sv =====
// ple_chain: row of DEPTH cells; decodes the chain operation per cell.
// Insert shifts toward the tail, delete and rotate shift toward the head.
// Depends on ple_pkg and ple_cell.
`timescale 1ns / 1ps

module ple_chain (
    input  logic                i_clk,
    input  ple_pkg::t_chain_ctl i_ctl,
    output ple_pkg::t_data      o_head
);
    import ple_pkg::*;

    t_data      w_data [DEPTH];
    t_cell_mode w_mode [DEPTH];
    t_data      w_left [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(g);

        // head cell has no left neighbor
        if (g == 0) begin : g_first
            assign w_left[g] = i_ctl.value;
        end else begin : g_rest
            assign w_left[g] = w_data[g-1];
        end

        // mode of this cell from the chain operation and the target index
        always_comb begin
            case (i_ctl.op)
                CHAIN_INS: begin
                    if (CELL_IDX > i_ctl.idx) begin
                        w_mode[g] = CELL_FROM_LEFT;
                    end else if (CELL_IDX == i_ctl.idx) begin
                        w_mode[g] = CELL_LOAD;
                    end else begin
                        w_mode[g] = CELL_HOLD;
                    end
                end
                CHAIN_DEL: begin
                    w_mode[g] = (CELL_IDX >= i_ctl.idx) ? CELL_FROM_RIGHT : CELL_HOLD;
                end
                CHAIN_ROT: w_mode[g] = CELL_FROM_RIGHT;
                default:   w_mode[g] = CELL_HOLD;
            endcase
        end

        // tail cell wraps to the head cell for rotation
        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode[g]),
            .i_load  (i_ctl.value),
            .i_left  (w_left[g]),
            .i_right (w_data[(g + 1) % DEPTH]),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

// ===== hw/rtl/positional_list_engine_unit.sv =====
// positional_list_engine_unit: top level of the positional list engine.
// Depends on ple_pkg and ple_chain (which uses ple_cell).
//
//  Channel | Dir | Sideband      | tdata fields, low bit up
//  s_*     | in  | tuser = func  | value[31:0], position[36:32], zero to 39
//  m_*     | out | tuser = status| result_value[31:0], result_position[36:32],
//          |     | tlast = last  | entry_count[41:37], zero to 47
//
// One request at a time. Sum, search and dump rotate the chain once fully
// past the head cell, one entry a cycle while a dump is not stalled; on an
// empty list they only report an empty status.
// Reset (i_rst_n low, synchronous) empties the list; entries are not cleared.
// A stalled result holds in the output register; a dump stops rotating while
// its next entry cannot be placed.
`timescale 1ns / 1ps

module positional_list_engine_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ple_pkg::IN_DATA_W-1:0]     s_tdata,  // value, position
    input  logic [ple_pkg::FUNC_W-1:0]        s_tuser,  // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ple_pkg::OUT_DATA_W-1:0]    m_tdata,  // value, position, count
    output logic [ple_pkg::STAT_W-1:0]        m_tuser,  // status
    output logic                              m_tlast   // last
);
    import ple_pkg::*;

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int PAD_W = OUT_DATA_W - DATA_W - 2 * POS_W;

    // control registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [IDX_W-1:0]  r_k, n_k;
    logic              r_found, n_found;
    logic              r_m_valid;

    // request and working payload
    t_func             r_func;
    t_data             r_value;
    logic [POS_W-1:0]  r_pos;
    t_data             r_acc, n_acc;
    logic [POS_W-1:0]  r_fpos, n_fpos;

    // output payload
    t_status           r_m_stat;
    t_data             r_m_val;
    logic [POS_W-1:0]  r_m_pos;
    logic [POS_W-1:0]  r_m_cnt;
    logic              r_m_last;

    // result to load
    logic              w_out_load;
    t_status           w_out_stat;
    t_data             w_out_val;
    logic [POS_W-1:0]  w_out_pos;
    logic              w_out_last;

    t_chain_ctl        w_ctl;
    t_data             w_head;

    logic              w_accept;
    logic              w_out_free;
    logic [CMP_W-1:0]  w_cnt_x, w_pos_x, w_ncnt_x;
    logic [IDX_W-1:0]  w_pos_idx;
    logic              w_full;
    logic              w_ins_bad, w_del_bad;
    logic [CNT_W-1:0]  w_k_x;
    logic [CNT_W-1:0]  w_dump_n;
    logic              w_k_live, w_k_dump;
    logic              w_step;

    assign s_tready   = (r_state == S_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_m_valid || m_tready;

    // range checks on the requested position
    assign w_cnt_x   = CMP_W'(r_count);
    assign w_pos_x   = CMP_W'(r_pos);
    assign w_pos_idx = IDX_W'(w_pos_x - 1'b1);
    assign w_full    = (r_count >= CNT_W'(DEPTH));
    assign w_ins_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x + 1'b1);
    assign w_del_bad = (w_pos_x == '0) || (w_pos_x > w_cnt_x);

    // scan position (1-based) and its limits
    assign w_k_x    = CNT_W'(r_k) + 1'b1;
    assign w_dump_n = (r_count > CNT_W'(DUMP_MAX)) ? CNT_W'(DUMP_MAX) : r_count;
    assign w_k_live = (w_k_x <= r_count);
    assign w_k_dump = (w_k_x <= w_dump_n);
    assign w_step   = (r_func == FN_DUMP && w_k_dump) ? w_out_free : 1'b1;

    assign w_ncnt_x = CMP_W'(n_count);

    // sequencer: next state, chain control and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_k        = r_k;
        n_found    = r_found;
        n_acc      = r_acc;
        n_fpos     = r_fpos;
        w_ctl.op    = CHAIN_HOLD;
        w_ctl.idx   = '0;
        w_ctl.value = r_value;
        w_out_load = 1'b0;
        w_out_stat = ST_OK;
        w_out_val  = '0;
        w_out_pos  = '0;
        w_out_last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                case (r_func)
                    FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
                        if (w_out_free) begin
                            n_state    = S_IDLE;
                            w_out_load = 1'b1;
                            if (w_full) begin
                                w_out_stat = ST_FULL;
                            end else if (r_func == FN_INS_POS && w_ins_bad) begin
                                w_out_stat = ST_BADPOS;
                            end else begin
                                w_ctl.op = CHAIN_INS;
                                if (r_func == FN_INS_HEAD) begin
                                    w_ctl.idx = '0;
                                end else if (r_func == FN_INS_TAIL) begin
                                    w_ctl.idx = IDX_W'(r_count);
                                end else begin
                                    w_ctl.idx = w_pos_idx;
                                end
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
                        if (w_out_free) begin
                            n_state    = S_IDLE;
                            w_out_load = 1'b1;
                            if (r_count == '0) begin
                                w_out_stat = ST_EMPTY;
                            end else if (r_func == FN_DEL_POS && w_del_bad) begin
                                w_out_stat = ST_BADPOS;
                            end else begin
                                w_ctl.op = CHAIN_DEL;
                                if (r_func == FN_DEL_HEAD) begin
                                    w_ctl.idx = '0;
                                end else if (r_func == FN_DEL_TAIL) begin
                                    w_ctl.idx = IDX_W'(r_count - 1'b1);
                                end else begin
                                    w_ctl.idx = w_pos_idx;
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                    end
                    FN_SUM, FN_SEARCH, FN_DUMP: begin
                        if (r_count == '0) begin
                            if (w_out_free) begin
                                n_state    = S_IDLE;
                                w_out_load = 1'b1;
                                w_out_stat = ST_EMPTY;
                            end
                        end else begin
                            n_state = S_SCAN;
                            n_k     = '0;
                            n_acc   = '0;
                            n_found = 1'b0;
                            n_fpos  = '0;
                        end
                    end
                    default: begin
                        if (w_out_free) begin
                            n_state    = S_IDLE;
                            w_out_load = 1'b1;
                        end
                    end
                endcase
            end

            // one full rotation; the head cell presents entry r_k + 1
            S_SCAN: begin
                if (w_step) begin
                    w_ctl.op = CHAIN_ROT;
                    n_k      = r_k + 1'b1;
                    if (r_func == FN_SUM && w_k_live) begin
                        n_acc = r_acc + w_head;
                    end
                    if (r_func == FN_SEARCH && w_k_live && !r_found && w_head == r_value) begin
                        n_found = 1'b1;
                        n_fpos  = POS_W'(w_k_x);
                    end
                    if (r_func == FN_DUMP && w_k_dump) begin
                        w_out_load = 1'b1;
                        w_out_val  = w_head;
                        w_out_pos  = POS_W'(w_k_x);
                        w_out_last = (w_k_x == w_dump_n);
                    end
                    if (r_k == IDX_W'(DEPTH - 1)) begin
                        n_state = (r_func == FN_DUMP) ? S_IDLE : S_FIN;
                    end
                end
            end

            S_FIN: begin
                if (w_out_free) begin
                    n_state    = S_IDLE;
                    w_out_load = 1'b1;
                    if (r_func == FN_SUM) begin
                        w_out_val = r_acc;
                    end else if (r_found) begin
                        w_out_pos = r_fpos;
                    end else begin
                        w_out_stat = ST_NOTFOUND;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_k     <= n_k;
            r_found <= n_found;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // request capture, accumulators and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func  <= t_func'(s_tuser);
            r_value <= s_tdata[DATA_W-1:0];
            r_pos   <= s_tdata[DATA_W +: POS_W];
        end
        r_acc  <= n_acc;
        r_fpos <= n_fpos;
        if (w_out_load) begin
            r_m_stat <= w_out_stat;
            r_m_val  <= w_out_val;
            r_m_pos  <= w_out_pos;
            r_m_cnt  <= w_ncnt_x[POS_W-1:0];
            r_m_last <= w_out_last;
        end
    end

    ple_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {{PAD_W{1'b0}}, r_m_cnt, r_m_pos, r_m_val};
    assign m_tuser  = r_m_stat;
    assign m_tlast  = r_m_last;

endmodule

// ===== hw/rtl/ple_checker.sv =====
// ple_checker: port-level assertions for positional_list_engine_unit,
// attached to the top level by the bind statement below. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [ple_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic [ple_pkg::STAT_W-1:0]        m_tuser,
    input logic                              m_tlast
);
    import ple_pkg::*;

    logic [POS_W-1:0] w_cnt;

    assign w_cnt    = m_tdata[DATA_W + POS_W +: POS_W];

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // one request at a time: no accept in the cycle after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a full report comes with a full list
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ST_FULL |-> w_cnt == POS_W'(DEPTH) && m_tlast)
        else $error("full status with list not full");

    // an empty report comes with an empty list, as a single result
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser == ST_EMPTY |-> w_cnt == '0 && m_tlast)
        else $error("empty status with entries present");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (.*);
